### design/button_press_classifier_macros.svh
// assertion macros for the button press classifier
// used by the controller and datapath modules; no other dependencies
`ifndef BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`define BUTTON_PRESS_CLASSIFIER_MACROS_SVH
`ifndef SYNTH
`define BPC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
`define BPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define BPC_ASSERT_SAME(label, clk, rst, ante, cons, msg)
`define BPC_ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif
`endif

### design/bpc_pkg.sv
// shared types and constants for the button press classifier
// no dependencies
`default_nettype none
package bpc_pkg;

   localparam int CNT_W  = 16;
   localparam int CFG_W  = 16;
   localparam int THR_W  = 8;
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int STEP_W = $clog2(CNT_W);
   localparam int IDX_W  = 3;

   localparam logic [1:0] PH_IDLE     = 2'd0;
   localparam logic [1:0] PH_PUSHED   = 2'd1;
   localparam logic [1:0] PH_RELEASED = 2'd2;
   localparam logic [1:0] PH_UNUSED   = 2'd3;

   localparam logic [IDX_W-1:0] REG_PRESS_THRESHOLD = 3'd0;
   localparam logic [IDX_W-1:0] REG_LOCK_TIME       = 3'd1;
   localparam logic [IDX_W-1:0] REG_LONG_PRESS_TIME = 3'd2;
   localparam logic [IDX_W-1:0] REG_REPEAT_PERIOD   = 3'd3;
   localparam logic [IDX_W-1:0] REG_VERY_LONG_TIME  = 3'd4;

   localparam logic [THR_W-1:0] RST_PRESS_THRESHOLD = 8'd7;
   localparam logic [CFG_W-1:0] RST_LOCK_TIME       = 16'd30;
   localparam logic [CFG_W-1:0] RST_LONG_PRESS_TIME = 16'd300;
   localparam logic [CFG_W-1:0] RST_REPEAT_PERIOD   = 16'd65;
   localparam logic [CFG_W-1:0] RST_VERY_LONG_TIME  = 16'd2000;

   typedef struct packed {
      logic [THR_W-1:0] press_threshold;
      logic [CFG_W-1:0] lock_time;
      logic [CFG_W-1:0] long_press_time;
      logic [CFG_W-1:0] repeat_period;
      logic [CFG_W-1:0] very_long_time;
   } cfg_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } cmd_type;

endpackage
`default_nettype wire

### design/bpc_csr.sv
// configuration registers of the button press classifier
// depends on bpc_pkg
`default_nettype none
module bpc_csr (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        csr_we,
   input  wire logic [bpc_pkg::IDX_W-1:0]   csr_index,
   input  wire logic [bpc_pkg::CFG_W-1:0]   csr_wdata,
   output bpc_pkg::cfg_type                 cfg
);

   bpc_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            bpc_pkg::REG_PRESS_THRESHOLD:
               cfg_in.press_threshold = csr_wdata[bpc_pkg::THR_W-1:0];
            bpc_pkg::REG_LOCK_TIME:       cfg_in.lock_time       = csr_wdata;
            bpc_pkg::REG_LONG_PRESS_TIME: cfg_in.long_press_time = csr_wdata;
            bpc_pkg::REG_REPEAT_PERIOD:   cfg_in.repeat_period   = csr_wdata;
            bpc_pkg::REG_VERY_LONG_TIME:  cfg_in.very_long_time  = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.press_threshold <= bpc_pkg::RST_PRESS_THRESHOLD;
         cfg_ff.lock_time       <= bpc_pkg::RST_LOCK_TIME;
         cfg_ff.long_press_time <= bpc_pkg::RST_LONG_PRESS_TIME;
         cfg_ff.repeat_period   <= bpc_pkg::RST_REPEAT_PERIOD;
         cfg_ff.very_long_time  <= bpc_pkg::RST_VERY_LONG_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

### design/bpc_ctrl.sv
// controller of the button press classifier: request accept, remainder steps, commit
// depends on bpc_pkg and button_press_classifier_macros.svh
`default_nettype none
`include "button_press_classifier_macros.svh"
module bpc_ctrl (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output bpc_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_DONE
   } state_type;

   state_type                   state_ff, state_in;
   logic [bpc_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                        rsp_tvalid_ff, rsp_tvalid_in;
   logic                        out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      cmd           = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               step_in  = '0;
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.step = 1'b1;
            step_in  = step_ff + 1'b1;
            if (step_ff == bpc_pkg::STEP_W'(bpc_pkg::CNT_W - 1)) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.commit    = 1'b1;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         step_ff       <= '0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   `BPC_ASSERT_SAME(a_commit_free, clock, reset, cmd.commit, out_free, "commit over a held response")
   `BPC_ASSERT_NEXT(a_commit_valid, clock, reset, cmd.commit, rsp_tvalid_ff, "commit lost response")
   `BPC_ASSERT_NEXT(a_load_div, clock, reset, req_tvalid && req_tready, (state_ff == ST_DIV) && (step_ff == '0), "request did not start remainder")

endmodule
`default_nettype wire

### design/bpc_dp.sv
// datapath of the button press classifier: phase, counter, flags, bit-serial remainder
// depends on bpc_pkg and button_press_classifier_macros.svh
`default_nettype none
`include "button_press_classifier_macros.svh"
module bpc_dp (
   input  wire logic             clock,
   input  wire logic             reset,
   input  bpc_pkg::cfg_type      cfg,
   input  bpc_pkg::cmd_type      cmd,
   input  wire logic             button_pressed,
   output logic [7:0]            rsp_tdata
);

   localparam int CNT_W = bpc_pkg::CNT_W;
   localparam int CFG_W = bpc_pkg::CFG_W;
   localparam int CMP_W = bpc_pkg::CMP_W;
   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   logic [1:0]       phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             action_ff, action_in;
   logic             lock_ff, lock_in;
   logic             long_ff, long_in;
   logic             repeat_ff, repeat_in;
   logic             very_ff, very_in;
   logic             pressed_ff;
   logic [CNT_W-1:0] cnt_new_ff, cnt_new_in;
   logic [CNT_W-1:0] dvd_ff;
   logic [CFG_W-1:0] rem_ff;
   logic [6:0]       out_ff;

   logic [CNT_W-1:0] cnt_inc;
   logic [CFG_W-1:0] per_eff;
   logic [CMP_W-1:0] thr_eff;
   logic [CFG_W:0]   trial;
   logic [CFG_W-1:0] rem_next;
   logic [CMP_W-1:0] cnt_cmp;

   assign cnt_inc = (count_ff == CNT_MAX) ? count_ff : count_ff + 1'b1;
   assign per_eff = (cfg.repeat_period == '0) ? CFG_W'(1) : cfg.repeat_period;
   assign thr_eff = (cfg.press_threshold == '0) ? CMP_W'(1) : CMP_W'(cfg.press_threshold);
   assign cnt_cmp = CMP_W'(cnt_new_ff);

   // count after the tick, before phase decisions
   always_comb begin
      case (phase_ff)
         bpc_pkg::PH_IDLE:
            cnt_new_in = button_pressed ? cnt_inc :
                         ((count_ff != '0) ? count_ff - 1'b1 : count_ff);
         bpc_pkg::PH_PUSHED:   cnt_new_in = button_pressed ? cnt_inc : '0;
         bpc_pkg::PH_RELEASED: cnt_new_in = button_pressed ? count_ff : cnt_inc;
         default:              cnt_new_in = count_ff;
      endcase
   end

   // restoring remainder, one dividend bit per step
   assign trial    = {rem_ff, dvd_ff[CNT_W-1]};
   assign rem_next = (trial >= {1'b0, per_eff}) ? CFG_W'(trial - {1'b0, per_eff}) :
                     trial[CFG_W-1:0];

   always_comb begin
      phase_in  = phase_ff;
      count_in  = cnt_new_ff;
      action_in = action_ff;
      lock_in   = lock_ff;
      long_in   = long_ff;
      repeat_in = repeat_ff;
      very_in   = very_ff;
      case (phase_ff)
         bpc_pkg::PH_IDLE: begin
            if (cnt_cmp >= thr_eff) begin
               action_in = 1'b1;
               lock_in   = 1'b1;
               phase_in  = bpc_pkg::PH_PUSHED;
               count_in  = '0;
            end else if (cnt_new_ff == '0) begin
               action_in = 1'b0;
               lock_in   = 1'b0;
            end
         end
         bpc_pkg::PH_PUSHED: begin
            if (!pressed_ff) begin
               phase_in = bpc_pkg::PH_RELEASED;
            end
            long_in = long_ff || (cnt_cmp == CMP_W'(cfg.long_press_time));
            if (long_in && (rem_ff == '0)) begin
               repeat_in = 1'b1;
            end
            if (cnt_cmp >= CMP_W'(cfg.very_long_time)) begin
               very_in = 1'b1;
            end
         end
         bpc_pkg::PH_RELEASED: begin
            if (cnt_cmp >= CMP_W'(cfg.lock_time)) begin
               action_in = 1'b0;
               lock_in   = 1'b0;
               long_in   = 1'b0;
               repeat_in = 1'b0;
               very_in   = 1'b0;
               phase_in  = bpc_pkg::PH_IDLE;
               count_in  = '0;
            end
         end
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= bpc_pkg::PH_IDLE;
         count_ff  <= '0;
         action_ff <= 1'b0;
         lock_ff   <= 1'b0;
         long_ff   <= 1'b0;
         repeat_ff <= 1'b0;
         very_ff   <= 1'b0;
      end else if (cmd.commit) begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         action_ff <= action_in;
         lock_ff   <= lock_in;
         long_ff   <= long_in;
         repeat_ff <= repeat_in;
         very_ff   <= very_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pressed_ff <= button_pressed;
         cnt_new_ff <= cnt_new_in;
         dvd_ff     <= cnt_new_in;
         rem_ff     <= '0;
      end else if (cmd.step) begin
         dvd_ff <= {dvd_ff[CNT_W-2:0], 1'b0};
         rem_ff <= rem_next;
      end
      if (cmd.commit) begin
         out_ff <= {very_in, repeat_in, long_in, lock_in, action_in, phase_in};
      end
   end

   // phase, action, locked, long_press, repeat_flag, very_long_press, pad
   assign rsp_tdata = {1'b0, out_ff};

   `BPC_ASSERT_SAME(a_phase_code, clock, reset, 1'b1, phase_ff != bpc_pkg::PH_UNUSED, "unused phase code reached")
   `BPC_ASSERT_NEXT(a_rem_bound, clock, reset, cmd.step, rem_ff < per_eff, "remainder out of range")

endmodule
`default_nettype wire

### design/button_press_classifier.sv
// top level of the button press classifier
// depends on bpc_pkg, bpc_csr, bpc_ctrl and bpc_dp
// Each request is one millisecond tick carrying the button level; each tick returns
// one response with the phase (idle, pushed, released) and the action, lock, long,
// repeat and very-long flags after the update. A request is first taken, then the
// bit-serial remainder unit works one counter bit per step to check the held count
// against the repeat period, and last the new state is committed into the response
// register once it is free. The next request is taken while a committed response
// still waits on rsp_tready. Configuration registers are written through csr_we,
// csr_index and csr_wdata; the user must do so only while no request is in flight,
// as the block does not enforce it. Indexes beyond the register list are ignored.
`default_nettype none
module button_press_classifier (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [7:0]                 req_tdata,  // button_pressed, pad
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   // phase[1:0], action, locked, long_press, repeat_flag, very_long_press, pad
   output logic [7:0]                      rsp_tdata,
   input  wire logic                       csr_we,
   input  wire logic [bpc_pkg::IDX_W-1:0]  csr_index,
   input  wire logic [bpc_pkg::CFG_W-1:0]  csr_wdata
);

   bpc_pkg::cfg_type cfg;
   bpc_pkg::cmd_type cmd;

   bpc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   bpc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   bpc_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cfg            (cfg),
      .cmd            (cmd),
      .button_pressed (req_tdata[0]),
      .rsp_tdata      (rsp_tdata)
   );

endmodule
`default_nettype wire
